// ===== rtl/i2cram_pkg.sv =====
// Shared types, codes and constants of the two-bus I2C RAM access master.
// No dependencies; used by i2cram_core, i2c_ram_access_master and tb_top.
package i2cram_pkg;

  localparam int unsigned INST_WORD_BITS_DEF = 16;
  localparam int unsigned DATA_WORD_BITS_DEF = 8;
  localparam int unsigned ADDR_BITS          = 8;
  localparam int unsigned WORD_BITS          = 16;
  localparam int unsigned CFG_IDX_BITS       = 1;

  localparam logic [ADDR_BITS-1:0] INST_DEV_RST = 8'hA0;
  localparam logic [ADDR_BITS-1:0] DATA_DEV_RST = 8'hA2;
  localparam logic [ADDR_BITS-1:0] RW_MASK      = 8'hFE;
  localparam logic [ADDR_BITS-1:0] RW_READ      = 8'h01;

  localparam logic [CFG_IDX_BITS-1:0] REG_INST_DEV = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DATA_DEV = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'h0001,
    ST_START    = 15'h0002,
    ST_DEV      = 15'h0004,
    ST_ACK_DEV  = 15'h0008,
    ST_ADDR     = 15'h0010,
    ST_ACK_ADDR = 15'h0020,
    ST_RSTART   = 15'h0040,
    ST_DEVR     = 15'h0080,
    ST_ACK_DEVR = 15'h0100,
    ST_READ     = 15'h0200,
    ST_NACK     = 15'h0400,
    ST_WWORD    = 15'h0800,
    ST_ACK_WORD = 15'h1000,
    ST_STOP     = 15'h2000,
    ST_FSTOP    = 15'h4000
  } state_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 bus_sel;
    logic [ADDR_BITS-1:0] mem_address;
    logic [WORD_BITS-1:0] write_word;
    logic                 sda_in;
  } item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 active_bus;
    logic                 busy_res;
    logic                 done_res;
    logic [WORD_BITS-1:0] read_word;
    logic                 nack_retry;
  } result_t;

endpackage

// ===== rtl/i2cram_core.sv =====
// Transaction sequencer: state registers and the per-request step logic.
// Depends on i2cram_pkg.
module i2cram_core #(
  parameter int unsigned INST_WORD_BITS = i2cram_pkg::INST_WORD_BITS_DEF,
  parameter int unsigned DATA_WORD_BITS = i2cram_pkg::DATA_WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  i2cram_pkg::item_t                   item_i,
  input  logic [i2cram_pkg::ADDR_BITS-1:0]    inst_dev_i,
  input  logic [i2cram_pkg::ADDR_BITS-1:0]    data_dev_i,
  output i2cram_pkg::result_t                 res_o
);
  import i2cram_pkg::*;

  localparam int unsigned WMAX  = (INST_WORD_BITS > DATA_WORD_BITS) ?
                                  INST_WORD_BITS : DATA_WORD_BITS;
  localparam int unsigned CNT_W = $clog2(((WMAX > WORD_BITS) ? WMAX : WORD_BITS) + 1);

  state_e               st_q, st_d;
  logic [1:0]           sub_q, sub_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WORD_BITS-1:0] sh_q, sh_d;
  logic                 op_wr_q, op_wr_d;
  logic                 bus_q, bus_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [WORD_BITS-1:0] dat_q, dat_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 drv_q, drv_d;

  logic                 scl_n;
  logic                 done;
  logic                 nack;
  logic                 drop_scl;
  logic [CNT_W-1:0]     bit_idx;
  logic                 tx_bit;
  logic [CNT_W-1:0]     word_bits;
  logic [ADDR_BITS-1:0] dev_byte;
  logic [WORD_BITS-1:0] sh_in;
  logic [CNT_W-1:0]     cnt_dec;

  always_comb begin
    word_bits = bus_q ? CNT_W'(INST_WORD_BITS) : CNT_W'(DATA_WORD_BITS);
    dev_byte  = bus_q ? inst_dev_i : data_dev_i;
    bit_idx   = cnt_q - CNT_W'(1);
    tx_bit    = (cnt_q != '0) && (bit_idx < CNT_W'(WORD_BITS)) && sh_q[bit_idx[3:0]];
    sh_in     = {sh_q[WORD_BITS-2:0], item_i.sda_in};
    cnt_dec   = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
  end

  always_comb begin
    st_d     = st_q;
    sub_d    = sub_q;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    op_wr_d  = op_wr_q;
    bus_d    = bus_q;
    addr_d   = addr_q;
    dat_d    = dat_q;
    rd_d     = rd_q;
    scl_n    = scl_q;
    sda_d    = sda_q;
    drv_d    = drv_q;
    done     = 1'b0;
    nack     = 1'b0;
    drop_scl = 1'b0;
    if (step_i) begin
      if (item_i.cmd == CMD_READ || item_i.cmd == CMD_WRITE) begin
        if (st_q == ST_IDLE) begin
          op_wr_d = (item_i.cmd == CMD_WRITE);
          bus_d   = item_i.bus_sel;
          addr_d  = item_i.mem_address;
          dat_d   = item_i.write_word;
          st_d    = ST_START;
          sub_d   = 2'd0;
        end
      end else if (item_i.cmd == CMD_TICK && st_q != ST_IDLE) begin
        case (st_q)
          ST_START, ST_RSTART: begin
            case (sub_q)
              2'd0: begin
                drv_d = 1'b1;
                sda_d = 1'b1;
              end
              2'd1: scl_n = 1'b1;
              2'd2: sda_d = 1'b0;
              default: scl_n = 1'b0;
            endcase
            sub_d = sub_q + 2'd1;
            if (sub_q == 2'd3) begin
              cnt_d = CNT_W'(ADDR_BITS);
              if (st_q == ST_START) begin
                st_d = ST_DEV;
                sh_d = WORD_BITS'(dev_byte & RW_MASK);
              end else begin
                st_d = ST_DEVR;
                sh_d = WORD_BITS'(dev_byte | RW_READ);
              end
            end
          end
          ST_DEV, ST_ADDR, ST_DEVR, ST_WWORD: begin
            case (sub_q)
              2'd0: begin
                drv_d = 1'b1;
                sda_d = tx_bit;
              end
              2'd1: scl_n = 1'b1;
              default: scl_n = 1'b0;
            endcase
            sub_d = sub_q + 2'd1;
            if (sub_q == 2'd2) begin
              sub_d = 2'd0;
              cnt_d = cnt_dec;
              if (cnt_dec == '0) begin
                case (st_q)
                  ST_DEV:  st_d = ST_ACK_DEV;
                  ST_ADDR: st_d = ST_ACK_ADDR;
                  ST_DEVR: st_d = ST_ACK_DEVR;
                  default: st_d = ST_ACK_WORD;
                endcase
              end
            end
          end
          ST_ACK_DEV, ST_ACK_ADDR, ST_ACK_DEVR, ST_ACK_WORD: begin
            drv_d    = 1'b0;
            scl_n    = 1'b1;
            drop_scl = 1'b1;
            sub_d    = 2'd0;
            if (item_i.sda_in) begin
              nack = 1'b1;
              st_d = ST_FSTOP;
            end else begin
              case (st_q)
                ST_ACK_DEV: begin
                  st_d  = ST_ADDR;
                  sh_d  = WORD_BITS'(addr_q);
                  cnt_d = CNT_W'(ADDR_BITS);
                end
                ST_ACK_ADDR: begin
                  if (op_wr_q) begin
                    st_d  = ST_WWORD;
                    sh_d  = dat_q;
                    cnt_d = word_bits;
                  end else begin
                    st_d = ST_RSTART;
                  end
                end
                ST_ACK_DEVR: begin
                  st_d  = ST_READ;
                  sh_d  = '0;
                  cnt_d = word_bits;
                  rd_d  = '0;
                end
                default: st_d = ST_STOP;
              endcase
            end
          end
          ST_READ: begin
            drv_d = 1'b0;
            if (sub_q == 2'd0) begin
              scl_n = 1'b0;
              sub_d = 2'd1;
            end else begin
              scl_n = 1'b1;
              sh_d  = sh_in;
              sub_d = 2'd0;
              cnt_d = cnt_dec;
              if (cnt_dec == '0) begin
                rd_d     = sh_in;
                drop_scl = 1'b1;
                st_d     = ST_NACK;
              end
            end
          end
          ST_NACK: begin
            case (sub_q)
              2'd0: begin
                drv_d = 1'b1;
                sda_d = 1'b1;
              end
              2'd1: scl_n = 1'b1;
              default: scl_n = 1'b0;
            endcase
            sub_d = sub_q + 2'd1;
            if (sub_q == 2'd2) begin
              st_d  = ST_STOP;
              sub_d = 2'd0;
            end
          end
          default: begin
            case (sub_q)
              2'd0: begin
                drv_d = 1'b1;
                scl_n = 1'b0;
              end
              2'd1: sda_d = 1'b0;
              2'd2: scl_n = 1'b1;
              default: sda_d = 1'b1;
            endcase
            sub_d = sub_q + 2'd1;
            if (sub_q == 2'd3) begin
              sub_d = 2'd0;
              if (st_q == ST_STOP) begin
                done = 1'b1;
                st_d = ST_IDLE;
              end else begin
                st_d = ST_START;
              end
            end
          end
        endcase
      end
    end
    scl_d = drop_scl ? 1'b0 : scl_n;
  end

  always_comb begin
    res_o.scl_level  = scl_n;
    res_o.sda_level  = drv_d & sda_d;
    res_o.sda_drive  = drv_d;
    res_o.active_bus = bus_d;
    res_o.busy_res   = (st_d != ST_IDLE);
    res_o.done_res   = done;
    res_o.read_word  = (done && !op_wr_q) ? rd_q : '0;
    res_o.nack_retry = nack;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      sub_q   <= 2'd0;
      cnt_q   <= '0;
      sh_q    <= '0;
      op_wr_q <= 1'b0;
      bus_q   <= 1'b0;
      addr_q  <= '0;
      dat_q   <= '0;
      rd_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      sh_q    <= sh_d;
      op_wr_q <= op_wr_d;
      bus_q   <= bus_d;
      addr_q  <= addr_d;
      dat_q   <= dat_d;
      rd_q    <= rd_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> !res_o.busy_res)
    else $error("done reported while still busy");

  a_nack_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.nack_retry |-> !res_o.sda_drive && res_o.scl_level)
    else $error("missing ACK flagged outside an ACK slot");

  a_nack_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.nack_retry |=> st_q == ST_FSTOP && !scl_q)
    else $error("missing ACK did not lead to stop");

  a_word_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.done_res |-> res_o.read_word == '0)
    else $error("read word shown without done");

endmodule

// ===== rtl/i2c_ram_access_master.sv =====
// Top level of the two-bus I2C RAM access master: stream ports, device
// address registers and result register. Depends on i2cram_pkg, i2cram_core.
//
//   port group   dir   role
//   s_axis_*     in    command or tick request
//   m_axis_*     out   line levels and status, one per request
//   cfg_*        in    device address register writes
//
// One request is taken per cycle; its result is registered and shows the
// next cycle. The output register frees s_axis_tready whenever it is empty
// or being taken, so a stalled m_axis side holds one result and stops input.
// Reset leaves the sequencer idle with SCL high and SDA released.
module i2c_ram_access_master #(
  parameter int unsigned INST_WORD_BITS = i2cram_pkg::INST_WORD_BITS_DEF,
  parameter int unsigned DATA_WORD_BITS = i2cram_pkg::DATA_WORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // mem_address[7:0], write_word[23:8], sda_in[24], zero[31:25]
  input  logic [31:0]                          s_axis_tdata,
  // cmd[1:0], bus_sel[2]
  input  logic [2:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], read_word[18:3], zero[23:19]
  output logic [23:0]                          m_axis_tdata,
  // active_bus[0], busy_res[1], done_res[2], nack_retry[3]
  output logic [3:0]                           m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [i2cram_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [i2cram_pkg::ADDR_BITS-1:0]     cfg_data_i
);
  import i2cram_pkg::*;

  logic                 accept;
  item_t                item;
  result_t              res;
  result_t              res_q;
  logic                 vld_q, vld_d;
  logic [ADDR_BITS-1:0] inst_dev_q;
  logic [ADDR_BITS-1:0] data_dev_q;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item.cmd         = s_axis_tuser[1:0];
    item.bus_sel     = s_axis_tuser[2];
    item.mem_address = s_axis_tdata[7:0];
    item.write_word  = s_axis_tdata[23:8];
    item.sda_in      = s_axis_tdata[24];
  end

  i2cram_core #(
    .INST_WORD_BITS (INST_WORD_BITS),
    .DATA_WORD_BITS (DATA_WORD_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .item_i     (item),
    .inst_dev_i (inst_dev_q),
    .data_dev_i (data_dev_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_dev_q <= INST_DEV_RST;
      data_dev_q <= DATA_DEV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INST_DEV: inst_dev_q <= cfg_data_i;
        REG_DATA_DEV: data_dev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld_d = accept ? 1'b1 : (m_axis_tready ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {5'd0, res_q.read_word, res_q.sda_drive, res_q.sda_level,
                          res_q.scl_level};
  assign m_axis_tuser  = {res_q.nack_retry, res_q.done_res, res_q.busy_res,
                          res_q.active_bus};

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted request left no result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result is stalled");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item.cmd == CMD_READ || item.cmd == CMD_WRITE) |=> m_axis_tuser[1])
    else $error("command did not leave the master busy");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for i2c_ram_access_master: drives command and tick
// requests on the stream input and checks line levels and status per request.
// Depends on i2cram_pkg and the i2c_ram_access_master RTL.
module tb_top;
  import i2cram_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_CADENCE, RX_STARVE} rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata = '0;
  logic [2:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [23:0]             m_axis_tdata;
  logic [3:0]              m_axis_tuser;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [ADDR_BITS-1:0]    cfg_data_i = '0;

  i2c_ram_access_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // bus sequencer prediction
  logic [ADDR_BITS-1:0] inst_dev_reg = INST_DEV_RST;
  logic [ADDR_BITS-1:0] data_dev_reg = DATA_DEV_RST;
  state_e               line_phase = ST_IDLE;
  int unsigned          bit_slot = 0;
  int unsigned          bits_left = 0;
  logic [31:0]          shreg = '0;
  logic                 op_write = 1'b0;
  logic                 lat_bus = 1'b0;
  logic [7:0]           lat_addr = '0;
  logic [15:0]          lat_word = '0;
  logic [15:0]          read_acc = '0;
  logic                 scl_q = 1'b1;
  logic                 sda_q = 1'b1;
  logic                 drv_q = 1'b0;

  result_t     expected_lines[$];
  result_t     observed;
  result_t     wanted;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_count = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  assign observed = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tuser[0],
                     m_axis_tuser[1], m_axis_tuser[2], m_axis_tdata[18:3], m_axis_tuser[3]};

  function automatic logic [7:0] device_byte();
    return lat_bus ? inst_dev_reg : data_dev_reg;
  endfunction

  function automatic int unsigned word_width();
    return lat_bus ? INST_WORD_BITS_DEF : DATA_WORD_BITS_DEF;
  endfunction

  task automatic load_shift(state_e next, logic [31:0] value, int unsigned nbits);
    line_phase = next;
    shreg      = value;
    bits_left  = nbits;
    bit_slot   = 0;
  endtask

  task automatic advance_bus_model(cmd_e cmd, logic bus, logic [7:0] addr, logic [15:0] word,
                                   logic sdain);
    result_t     r;
    logic        done;
    logic        nack;
    logic        drop;
    logic [15:0] rword;
    done  = 1'b0;
    nack  = 1'b0;
    drop  = 1'b0;
    rword = '0;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (line_phase == ST_IDLE) begin
        op_write   = (cmd == CMD_WRITE);
        lat_bus    = bus;
        lat_addr   = addr;
        lat_word   = word;
        line_phase = ST_START;
        bit_slot   = 0;
      end
    end else if (cmd == CMD_TICK && line_phase != ST_IDLE) begin
      case (line_phase)
        ST_START, ST_RSTART: begin
          case (bit_slot)
            0: begin
              drv_q = 1'b1;
              sda_q = 1'b1;
            end
            1: scl_q = 1'b1;
            2: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
          bit_slot++;
          if (bit_slot >= 4) begin
            if (line_phase == ST_START) load_shift(ST_DEV, {24'b0, device_byte() & RW_MASK}, 8);
            else load_shift(ST_DEVR, {24'b0, device_byte() | RW_READ}, 8);
          end
        end
        ST_DEV, ST_ADDR, ST_DEVR, ST_WWORD: begin
          if (bit_slot == 0) begin
            drv_q = 1'b1;
            sda_q = (bits_left >= 1 && bits_left <= 32) ? shreg[bits_left-1] : 1'b0;
          end else if (bit_slot == 1) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
          bit_slot++;
          if (bit_slot >= 3) begin
            bit_slot = 0;
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) begin
              case (line_phase)
                ST_DEV:  line_phase = ST_ACK_DEV;
                ST_ADDR: line_phase = ST_ACK_ADDR;
                ST_DEVR: line_phase = ST_ACK_DEVR;
                default: line_phase = ST_ACK_WORD;
              endcase
            end
          end
        end
        ST_ACK_DEV, ST_ACK_ADDR, ST_ACK_DEVR, ST_ACK_WORD: begin
          drv_q = 1'b0;
          scl_q = 1'b1;
          drop  = 1'b1;
          if (sdain) begin
            nack       = 1'b1;
            line_phase = ST_FSTOP;
            bit_slot   = 0;
          end else begin
            case (line_phase)
              ST_ACK_DEV: load_shift(ST_ADDR, {24'b0, lat_addr}, 8);
              ST_ACK_ADDR: begin
                if (op_write) begin
                  load_shift(ST_WWORD, {16'b0, lat_word}, word_width());
                end else begin
                  line_phase = ST_RSTART;
                  bit_slot   = 0;
                end
              end
              ST_ACK_DEVR: begin
                load_shift(ST_READ, '0, word_width());
                read_acc = '0;
              end
              default: begin
                line_phase = ST_STOP;
                bit_slot   = 0;
              end
            endcase
          end
        end
        ST_READ: begin
          drv_q = 1'b0;
          if (bit_slot == 0) begin
            scl_q    = 1'b0;
            bit_slot = 1;
          end else begin
            scl_q    = 1'b1;
            shreg    = {shreg[30:0], sdain};
            bit_slot = 0;
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) begin
              read_acc   = shreg[15:0];
              drop       = 1'b1;
              line_phase = ST_NACK;
            end
          end
        end
        ST_NACK: begin
          if (bit_slot == 0) begin
            drv_q = 1'b1;
            sda_q = 1'b1;
          end else if (bit_slot == 1) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
          bit_slot++;
          if (bit_slot >= 3) begin
            line_phase = ST_STOP;
            bit_slot   = 0;
          end
        end
        default: begin
          case (bit_slot)
            0: begin
              drv_q = 1'b1;
              scl_q = 1'b0;
            end
            1: sda_q = 1'b0;
            2: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          bit_slot++;
          if (bit_slot >= 4) begin
            bit_slot = 0;
            if (line_phase == ST_STOP) begin
              done       = 1'b1;
              rword      = op_write ? 16'h0000 : read_acc;
              line_phase = ST_IDLE;
            end else begin
              line_phase = ST_START;
            end
          end
        end
      endcase
    end
    r.scl_level  = scl_q;
    r.sda_level  = drv_q ? sda_q : 1'b0;
    r.sda_drive  = drv_q;
    r.active_bus = lat_bus;
    r.busy_res   = (line_phase != ST_IDLE);
    r.done_res   = done;
    r.read_word  = rword;
    r.nack_retry = nack;
    expected_lines.push_back(r);
    if (drop) scl_q = 1'b0;
  endtask

  task automatic send_request(cmd_e cmd, logic bus, logic [7:0] addr, logic [15:0] word,
                              logic sdain);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, sdain, word, addr};
    s_axis_tuser  <= {bus, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_bus_model(cmd, bus, addr, word, sdain);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_device_reg(logic [CFG_IDX_BITS-1:0] idx, logic [ADDR_BITS-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_INST_DEV) inst_dev_reg = value;
    else data_dev_reg = value;
  endtask

  // run one access to completion; nack_at forces one missing ACK at that phase
  task automatic run_access(cmd_e cmd, logic bus, logic [7:0] addr, logic [15:0] word,
                            state_e nack_at, int unsigned nack_pct, int unsigned read_fill,
                            int unsigned noise_pct);
    int unsigned ticks;
    logic        forced;
    logic        sdain;
    ticks  = 0;
    forced = 1'b0;
    send_request(cmd, bus, addr, word, 1'($urandom_range(0, 1)));
    while (line_phase != ST_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_request(cmd_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), 8'($urandom),
                     16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        sdain = 1'($urandom_range(0, 1));
        if (line_phase == ST_ACK_DEV || line_phase == ST_ACK_ADDR ||
            line_phase == ST_ACK_DEVR || line_phase == ST_ACK_WORD) begin
          if (!forced && line_phase == nack_at) begin
            sdain  = 1'b1;
            forced = 1'b1;
          end else begin
            sdain = (ticks < 1500) && ($urandom_range(0, 99) < nack_pct);
          end
        end else if (line_phase == ST_READ && read_fill < 2) begin
          sdain = read_fill[0];
        end
        send_request(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), sdain);
        ticks++;
      end
    end
  endtask

  task automatic test_idle_lines();
    send_request(CMD_TICK, 1'b0, 8'h00, 16'h0000, 1'b0);
    send_request(CMD_TICK, 1'b1, 8'hFF, 16'hFFFF, 1'b1);
    send_request(CMD_NONE, 1'b1, 8'hFF, 16'hFFFF, 1'b1);
    send_request(CMD_NONE, 1'b0, 8'h00, 16'h0000, 1'b0);
    drain_results();
  endtask

  task automatic test_directed_access();
    run_access(CMD_WRITE, 1'b0, 8'h00, 16'hFFFF, ST_IDLE, 0, 2, 0);
    run_access(CMD_READ, 1'b1, 8'hFF, 16'h0000, ST_IDLE, 0, 1, 0);
    run_access(CMD_READ, 1'b0, 8'h5A, 16'h1234, ST_ACK_DEVR, 0, 0, 0);
    run_access(CMD_WRITE, 1'b1, 8'hC3, 16'hA5C3, ST_ACK_DEV, 0, 2, 0);
    run_access(CMD_READ, 1'b1, 8'h81, 16'h0000, ST_ACK_ADDR, 0, 2, 0);
    run_access(CMD_WRITE, 1'b0, 8'h7E, 16'h00FF, ST_ACK_WORD, 0, 2, 10);
    run_access(CMD_WRITE, 1'b1, 8'h3C, 16'h5A00, ST_IDLE, 0, 2, 10);
    drain_results();
  endtask

  task automatic test_device_regs();
    logic [7:0] setting;
    for (int k = 0; k < 2; k++) begin
      setting = (k == 0) ? 8'hFF : 8'h00;
      write_device_reg(REG_INST_DEV, setting);
      write_device_reg(REG_DATA_DEV, ~setting);
      for (int b = 0; b < 2; b++) begin
        run_access((k == 0) ? CMD_READ : CMD_WRITE, b[0], 8'($urandom), 16'($urandom),
                   ST_IDLE, 0, 2, 0);
      end
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int seg = 0; seg < 3; seg++) begin
      write_device_reg(REG_INST_DEV, 8'($urandom));
      write_device_reg(REG_DATA_DEV, 8'($urandom));
      target = items_sent + 100;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_NONE,
                       1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                       1'($urandom_range(0, 1)));
        end else begin
          run_access(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE,
                     1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                     ST_IDLE, 6, 2, 3);
        end
      end
      drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    rx_count <= rx_count + 1;
    if (rx_count % 128 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 9) < 7);
      RX_CADENCE: m_axis_tready <= (rx_count % 5 < 3);
      default:    m_axis_tready <= (rx_count % 16 < 4);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_lines.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result: %h", observed);
      end else begin
        wanted = expected_lines.pop_front();
        if (observed !== wanted) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected scl=%b sda=%b drv=%b bus=%b busy=%b done=%b word=%h nack=%b",
                     wanted.scl_level, wanted.sda_level, wanted.sda_drive, wanted.active_bus,
                     wanted.busy_res, wanted.done_res, wanted.read_word, wanted.nack_retry);
            $display("          actual   scl=%b sda=%b drv=%b bus=%b busy=%b done=%b word=%h nack=%b",
                     observed.scl_level, observed.sda_level, observed.sda_drive,
                     observed.active_bus, observed.busy_res, observed.done_res,
                     observed.read_word, observed.nack_retry);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_lines();
    test_directed_access();
    test_device_regs();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
